### src/bate_pkg.sv
// Shared types and constants for the bounded array table engine.
package bate_pkg;

   localparam int DEPTH  = 256;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int IDX_W  = 8;
   localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_READ   = 2'd1,
      OP_WRITE  = 2'd2,
      OP_SEARCH = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_RANGE  = 2'd1,
      ST_FULL   = 2'd2,
      ST_ABSENT = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_SCAN
   } state_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } mem_write_type;

   localparam logic signed [8:0] NO_INDEX = -9'sd1;

endpackage

### src/bate_store.sv
// Entry store: one write port and one read port with registered read data.
module bate_store
   import bate_pkg::*;
(
   input  logic              clock,
   input  mem_write_type     wr,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/bounded_array_table_engine_unit.sv
// Bounded array table engine: append, read, write and linear search over a fill-counted table.
// Append, write and any refused or out-of-range word: result in the next cycle, busy stays low.
// Read in range: S_READ registers the store's read data as the result; busy for one cycle.
// Search: absent from idle on an empty table, else a scan from index 0 up to the first hit or
// the last entry, busy while scanning; one store read and one 32-bit compare per cycle.
// Synchronous reset empties the table (count 0); entry contents are left as they are.
module bounded_array_table_engine_unit
   import bate_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_operation,
   input  logic [7:0]         req_index,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_read_value,
   output logic signed [8:0]  rsp_found_index,
   output logic [1:0]         rsp_status,
   output logic               rsp_is_empty,
   output logic [8:0]         rsp_fill_count
);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ADDR_W-1:0]  scan_ff, scan_in;
   logic [DATA_W-1:0]  value_ff, value_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  rsp_read_ff, rsp_read_in;
   logic signed [8:0]  rsp_found_ff, rsp_found_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_empty_ff, rsp_empty_in;
   logic [8:0]         rsp_fill_ff, rsp_fill_in;

   mem_write_type      wr;
   logic [ADDR_W-1:0]  rd_addr;
   logic [DATA_W-1:0]  rd_data;
   logic               accept;
   logic               in_range;
   logic               scan_last;
   logic               hit;

   bate_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign in_range  = CMP_W'(req_index) < CMP_W'(count_ff);
   assign scan_last = (CNT_W'(scan_ff) + CNT_W'(1)) == count_ff;
   assign hit       = (rd_data == value_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      value_ff      <= value_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      value_in      = value_ff;
      rsp_valid_in  = 1'b0;
      rsp_read_in   = '0;
      rsp_found_in  = NO_INDEX;
      rsp_status_in = ST_OK;
      wr            = '0;
      rd_addr       = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               value_in = req_value;
               case (op_type'(req_operation))
                  OP_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff < CNT_W'(DEPTH)) begin
                        wr.en    = 1'b1;
                        wr.addr  = ADDR_W'(count_ff);
                        wr.data  = req_value;
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        rsp_status_in = ST_FULL;
                     end
                  end
                  OP_READ: begin
                     if (in_range) begin
                        rd_addr  = ADDR_W'(req_index);
                        state_in = S_READ;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_RANGE;
                     end
                  end
                  OP_WRITE: begin
                     rsp_valid_in = 1'b1;
                     if (in_range) begin
                        wr.en   = 1'b1;
                        wr.addr = ADDR_W'(req_index);
                        wr.data = req_value;
                     end else begin
                        rsp_status_in = ST_RANGE;
                     end
                  end
                  OP_SEARCH: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_ABSENT;
                     end else begin
                        rd_addr  = '0;
                        scan_in  = '0;
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_valid_in = 1'b1;
            rsp_read_in  = rd_data;
            state_in     = S_IDLE;
         end
         S_SCAN: begin
            // rd_data holds the entry at scan_ff; fetch the next one ahead
            if (hit) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 9'(scan_ff);
               state_in     = S_IDLE;
            end else if (scan_last) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_ABSENT;
               state_in      = S_IDLE;
            end else begin
               scan_in = scan_ff + ADDR_W'(1);
               rd_addr = scan_ff + ADDR_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_fill_in  = 9'(count_in);
      rsp_empty_in = (count_in == '0);
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_read_ff;
   assign rsp_found_index = rsp_found_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_fill_count  = rsp_fill_ff;

endmodule

### dv/tb.sv
// Self-checking testbench for the bounded array table engine: directed table, then random words.
`timescale 1ns / 1ps

module tb
   import bate_pkg::*;
();

   localparam int  RESET_CYCLES = 12;
   localparam int  RANDOM_WORDS = 950;
   localparam int  MAX_GAP      = 13;
   localparam int  DRAIN_CYCLES = DEPTH + 8;
   localparam int  CYCLE_LIMIT  = 1_200_000;
   localparam int  REPORT_LIMIT = 10;
   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

   typedef struct {
      logic signed [31:0] read_value;
      logic signed [8:0]  found_index;
      status_type         status;
      logic               is_empty;
      logic [8:0]         fill_count;
   } table_result_type;

   typedef struct {
      op_type             op;
      logic [7:0]         idx;
      logic signed [31:0] val;
      bit                 typed;
      table_result_type   want;
   } table_row_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_operation;
   logic [7:0]         req_index;
   logic signed [31:0] req_value;
   logic               rsp_valid;
   logic signed [31:0] rsp_read_value;
   logic signed [8:0]  rsp_found_index;
   logic [1:0]         rsp_status;
   logic               rsp_is_empty;
   logic [8:0]         rsp_fill_count;

   logic signed [31:0] shadow_entries [DEPTH];
   int                 shadow_fill;
   table_result_type   pending_results [$];
   table_row_type      directed_rows [$];
   int                 mismatch_count;
   int                 cycle_count = 0;

   bounded_array_table_engine_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_index       (req_index),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_read_value  (rsp_read_value),
      .rsp_found_index (rsp_found_index),
      .rsp_status      (rsp_status),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_fill_count  (rsp_fill_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Apply one word to the shadow table and return the result it should produce.
   function automatic table_result_type apply_word(op_type op, logic [7:0] idx,
                                                   logic signed [31:0] val);
      table_result_type r;
      r.read_value  = '0;
      r.found_index = NO_INDEX;
      r.status      = ST_OK;
      case (op)
         OP_APPEND: begin
            if (shadow_fill < DEPTH) begin
               shadow_entries[ADDR_W'(shadow_fill)] = val;
               shadow_fill++;
            end else begin
               r.status = ST_FULL;
            end
         end
         OP_READ: begin
            if (int'(idx) < shadow_fill) r.read_value = shadow_entries[idx];
            else r.status = ST_RANGE;
         end
         OP_WRITE: begin
            if (int'(idx) < shadow_fill) shadow_entries[idx] = val;
            else r.status = ST_RANGE;
         end
         default: begin
            r.status = ST_ABSENT;
            for (int i = 0; i < shadow_fill; i++) begin
               if (shadow_entries[ADDR_W'(i)] == val) begin
                  r.found_index = 9'(i);
                  r.status      = ST_OK;
                  break;
               end
            end
         end
      endcase
      r.is_empty   = (shadow_fill == 0);
      r.fill_count = 9'(shadow_fill);
      return r;
   endfunction

   task automatic add_row(op_type op, int idx, logic signed [31:0] val, bit typed,
                          logic signed [31:0] rd, int fi, status_type st, bit em, int fc);
      table_row_type row;
      row.op                 = op;
      row.idx                = 8'(idx);
      row.val                = val;
      row.typed              = typed;
      row.want.read_value    = rd;
      row.want.found_index   = 9'(fi);
      row.want.status        = st;
      row.want.is_empty      = em;
      row.want.fill_count    = 9'(fc);
      directed_rows.push_back(row);
   endtask

   // Present one word after an idle gap and hold it until the engine takes it.
   task automatic send_word(op_type op, logic [7:0] idx, logic signed [31:0] val, int gap,
                            bit typed, table_result_type want);
      table_result_type predicted;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_operation <= op;
      req_index     <= idx;
      req_value     <= val;
      do @(posedge clock); while (busy);
      predicted = apply_word(op, idx, val);
      if (typed) predicted = want;
      pending_results.push_back(predicted);
   endtask

   always @(posedge clock) begin : check_results
      table_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            if (mismatch_count < REPORT_LIMIT)
               $display("unexpected result word: rd=%0d idx=%0d st=%0d empty=%0b cnt=%0d",
                        rsp_read_value, rsp_found_index, rsp_status, rsp_is_empty,
                        rsp_fill_count);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_read_value !== want.read_value || rsp_found_index !== want.found_index ||
                rsp_status !== want.status || rsp_is_empty !== want.is_empty ||
                rsp_fill_count !== want.fill_count) begin
               if (mismatch_count < REPORT_LIMIT) begin
                  $write("mismatch: exp rd=%0d idx=%0d st=%0d empty=%0b cnt=%0d",
                         want.read_value, want.found_index, want.status, want.is_empty,
                         want.fill_count);
                  $display(" / got rd=%0d idx=%0d st=%0d empty=%0b cnt=%0d",
                           rsp_read_value, rsp_found_index, rsp_status, rsp_is_empty,
                           rsp_fill_count);
               end
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      table_result_type   blank;
      op_type             op;
      logic [7:0]         idx;
      logic signed [31:0] val;
      int                 roll;
      int                 gap;
      bit                 burst;

      blank.read_value  = '0;
      blank.found_index = NO_INDEX;
      blank.status      = ST_OK;
      blank.is_empty    = 1'b0;
      blank.fill_count  = '0;
      burst          = 1'b0;
      shadow_fill    = 0;
      mismatch_count = 0;
      reset         <= 1'b1;
      start         <= 1'b0;
      req_operation <= OP_APPEND;
      req_index     <= '0;
      req_value     <= '0;

      // Empty table: every lookup misses; then two appends, with reads, searches and writes in and out of range.
      add_row(OP_READ,   0,   0,       1, 0,       NO_INDEX, ST_RANGE,  1, 0);
      add_row(OP_WRITE,  0,   VAL_MAX, 1, 0,       NO_INDEX, ST_RANGE,  1, 0);
      add_row(OP_SEARCH, 0,   0,       1, 0,       NO_INDEX, ST_ABSENT, 1, 0);
      add_row(OP_APPEND, 255, VAL_MIN, 1, 0,       NO_INDEX, ST_OK,     0, 1);
      add_row(OP_APPEND, 0,   VAL_MAX, 1, 0,       NO_INDEX, ST_OK,     0, 2);
      add_row(OP_READ,   0,   0,       1, VAL_MIN, NO_INDEX, ST_OK,     0, 2);
      add_row(OP_READ,   1,   VAL_MIN, 1, VAL_MAX, NO_INDEX, ST_OK,     0, 2);
      add_row(OP_READ,   2,   0,       1, 0,       NO_INDEX, ST_RANGE,  0, 2);
      add_row(OP_READ,   255, 0,       1, 0,       NO_INDEX, ST_RANGE,  0, 2);
      add_row(OP_SEARCH, 0,   VAL_MAX, 1, 0,       1,        ST_OK,     0, 2);
      add_row(OP_SEARCH, 0,   VAL_MIN, 1, 0,       0,        ST_OK,     0, 2);
      add_row(OP_SEARCH, 0,   5,       1, 0,       NO_INDEX, ST_ABSENT, 0, 2);
      add_row(OP_WRITE,  1,   -1,      1, 0,       NO_INDEX, ST_OK,     0, 2);
      add_row(OP_SEARCH, 0,   -1,      1, 0,       1,        ST_OK,     0, 2);
      add_row(OP_WRITE,  255, 7,       1, 0,       NO_INDEX, ST_RANGE,  0, 2);
      add_row(OP_WRITE,  2,   7,       1, 0,       NO_INDEX, ST_RANGE,  0, 2);
      // Duplicates: search must return the lowest matching index.
      add_row(OP_APPEND, 0,   0,       0, 0, 0, ST_OK, 0, 0);
      add_row(OP_APPEND, 0,   VAL_MAX, 0, 0, 0, ST_OK, 0, 0);
      add_row(OP_WRITE,  3,   0,       0, 0, 0, ST_OK, 0, 0);
      add_row(OP_SEARCH, 0,   0,       0, 0, 0, ST_OK, 0, 0);
      add_row(OP_READ,   3,   0,       0, 0, 0, ST_OK, 0, 0);
      add_row(OP_SEARCH, 170, 32'sh5555_5555, 0, 0, 0, ST_OK, 0, 0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_word(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].val,
                   $urandom_range(0, MAX_GAP), directed_rows[i].typed, directed_rows[i].want);

      // Appends take 35 percent of the words, so the table fills and later words run against a full table.
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 32 == 0) burst = ($urandom_range(0, 3) == 0);
         roll = $urandom_range(0, 99);
         if (roll < 35)      op = OP_APPEND;
         else if (roll < 55) op = OP_READ;
         else if (roll < 72) op = OP_WRITE;
         else                op = OP_SEARCH;
         if (shadow_fill > 0 && $urandom_range(0, 4) != 0)
            idx = 8'($urandom_range(0, shadow_fill - 1));
         else
            idx = 8'($urandom_range(0, 255));
         case ($urandom_range(0, 3))
            0, 1: val = $urandom;
            2: begin
               case ($urandom_range(0, 4))
                  0:       val = 0;
                  1:       val = -1;
                  2:       val = VAL_MIN;
                  3:       val = VAL_MAX;
                  default: val = 1;
               endcase
            end
            default: begin
               if (shadow_fill > 0)
                  val = shadow_entries[ADDR_W'($urandom_range(0, shadow_fill - 1))];
               else val = $urandom;
            end
         endcase
         gap = burst ? 0 : $urandom_range(0, MAX_GAP);
         send_word(op, idx, val, gap, 1'b0, blank);
      end
      // Drop start as soon as send_word returns for the last word, so no word is taken twice.
      start <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

### bounded_array_table_engine_unit.f
src/bate_pkg.sv
src/bate_store.sv
src/bounded_array_table_engine_unit.sv
dv/tb.sv
